// ===== rtl/core/m3i_pkg.sv =====
// Shared widths, types and index tables for the 3x3 matrix inverse.
`default_nettype none
package m3i_pkg;
    localparam int unsigned ENTRY_WIDTH = 16;
    localparam int unsigned N_ENT       = 9;
    localparam int unsigned N_PROD      = 2 * N_ENT;
    localparam int unsigned FRAC_W      = ENTRY_WIDTH - 4;
    localparam int unsigned OUT_SHIFT   = FRAC_W + 16;
    localparam int unsigned PROD_W      = 2 * ENTRY_WIDTH;
    localparam int unsigned ADJ_W       = 2 * ENTRY_WIDTH + 1;
    localparam int unsigned DET_W       = 3 * ENTRY_WIDTH + 3;
    localparam int unsigned OUT_W       = 32;
    localparam int unsigned QB          = OUT_W + 1;
    localparam int unsigned NUM_W       = ADJ_W + OUT_SHIFT;
    localparam int unsigned HI_W        = NUM_W - QB;
    localparam int unsigned IN_W        = ((N_ENT * ENTRY_WIDTH + 7) / 8) * 8;
    localparam int unsigned OUTD_W      = N_ENT * OUT_W;
    localparam int unsigned FRONT_LAT   = 5;
    localparam int unsigned LANE_LAT    = QB + 2;
    localparam int unsigned LAT         = FRONT_LAT + LANE_LAT;

    // operand pairs: adj(k) = e[PA[2k]]*e[PB[2k]] - e[PA[2k+1]]*e[PB[2k+1]]
    localparam int unsigned PA [N_PROD] = '{4, 7, 2, 8, 1, 4, 5, 8, 0, 6,
                                           2, 5, 3, 6, 1, 7, 0, 3};
    localparam int unsigned PB [N_PROD] = '{8, 5, 7, 1, 5, 2, 6, 3, 8, 2,
                                           3, 0, 7, 4, 6, 0, 4, 1};

    typedef logic signed [ENTRY_WIDTH-1:0] entry_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [ADJ_W-1:0]       adj_t;
    typedef logic signed [DET_W-1:0]       det_t;

    typedef struct packed {
        logic             sing;
        logic             neg;
        logic [DET_W-1:0] mag;
    } det_info_t;
endpackage
`default_nettype wire

// ===== rtl/core/matrix3x3_inverse_top.sv =====
// Top level: 3x3 matrix inverse by adjugate, nine divider lanes in parallel.
// Pipeline: 5 cofactor/determinant stages, then 35 stages per divider lane
// (one quotient bit per stage).
// Throughput: one matrix per cycle; the whole pipeline holds while a result waits.
// Reset: rst_n asynchronous, active low, clears the valid chain only.
`default_nettype none
module matrix3x3_inverse_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [m3i_pkg::IN_W-1:0]    s_tdata,   // m00,m01,m02,m10,m11,m12,m20,m21,m22
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [m3i_pkg::OUTD_W-1:0]       m_tdata,   // inv00,inv01,...,inv22
    output logic                             m_tuser    // singular
);
    import m3i_pkg::*;

    logic            en;
    logic [LAT-1:0]  vld_reg;
    logic [LAT-1:0]  vld_next;
    entry_t          ent  [N_ENT];
    adj_t            adj  [N_ENT];
    det_info_t       det;
    logic [OUT_W-1:0] quo [N_ENT];
    logic [N_ENT-1:0] sing;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    for (genvar k = 0; k < N_ENT; k++)
    begin : g_ent
        assign ent[k] = s_tdata[k*ENTRY_WIDTH +: ENTRY_WIDTH];
    end

    m3i_adj u_adj (
        .clk   (clk),
        .en    (en),
        .ent   (ent),
        .adj   (adj),
        .det   (det)
    );

    for (genvar k = 0; k < N_ENT; k++)
    begin : g_lane
        m3i_div_lane u_lane (
            .clk   (clk),
            .en    (en),
            .cof   (adj[k]),
            .det   (det),
            .quo   (quo[k]),
            .sing  (sing[k])
        );
        assign m_tdata[k*OUT_W +: OUT_W] = quo[k];
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tuser  = sing[0];

`ifndef NO_ASSERTIONS
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("singular result carries nonzero entries");
    a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (sing == '0 || sing == '1))
        else $error("lanes disagree on singular flag");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/m3i_adj.sv =====
// Cofactor and determinant pipeline, five stages.
`default_nettype none
module m3i_adj (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire m3i_pkg::entry_t     ent [m3i_pkg::N_ENT],
    output m3i_pkg::adj_t            adj [m3i_pkg::N_ENT],
    output m3i_pkg::det_info_t       det
);
    import m3i_pkg::*;

    prod_t     p_reg   [N_PROD];
    entry_t    e1_reg  [3];
    entry_t    e2_reg  [3];
    adj_t      a2_reg  [N_ENT];
    adj_t      a3_reg  [N_ENT];
    adj_t      a4_reg  [N_ENT];
    adj_t      a5_reg  [N_ENT];
    det_t      dp_reg  [3];
    det_t      det_reg;
    det_info_t info_reg;
    det_info_t info_next;

    always_comb
    begin
        info_next.sing = (det_reg == '0);
        info_next.neg  = det_reg[DET_W-1];
        info_next.mag  = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N_PROD; k++)
                p_reg[k] <= PROD_W'(ent[PA[k]] * ent[PB[k]]);
            for (int k = 0; k < 3; k++)
            begin
                e1_reg[k] <= ent[k];
                e2_reg[k] <= e1_reg[k];
            end
            for (int k = 0; k < N_ENT; k++)
            begin
                a2_reg[k] <= ADJ_W'(p_reg[2*k]) - ADJ_W'(p_reg[2*k+1]);
                a3_reg[k] <= a2_reg[k];
                a4_reg[k] <= a3_reg[k];
                a5_reg[k] <= a4_reg[k];
            end
            dp_reg[0] <= DET_W'(e2_reg[0] * a2_reg[0]);
            dp_reg[1] <= DET_W'(e2_reg[1] * a2_reg[3]);
            dp_reg[2] <= DET_W'(e2_reg[2] * a2_reg[6]);
            det_reg   <= dp_reg[0] + dp_reg[1] + dp_reg[2];
            info_reg  <= info_next;
        end
    end

    assign adj = a5_reg;
    assign det = info_reg;
endmodule
`default_nettype wire

// ===== rtl/core/m3i_div_lane.sv =====
// One quotient lane: cofactor * 2^OUT_SHIFT / det, one bit per stage, saturated.
`default_nettype none
module m3i_div_lane (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire m3i_pkg::adj_t         cof,
    input  wire m3i_pkg::det_info_t    det,
    output logic [m3i_pkg::OUT_W-1:0]  quo,
    output logic                       sing
);
    import m3i_pkg::*;

    localparam logic [QB-1:0] POS_LIM = QB'(64'h7FFF_FFFF);
    localparam logic [QB-1:0] NEG_LIM = QB'(64'h8000_0000);

    logic [ADJ_W-1:0] cm;
    logic [NUM_W-1:0] num;
    logic [HI_W-1:0]  hi;

    logic [DET_W-1:0] rem_reg  [QB+1];
    logic [QB-1:0]    lo_reg   [QB+1];
    logic [QB-1:0]    q_reg    [QB+1];
    logic [DET_W-1:0] dm_reg   [QB+1];
    logic             neg_reg  [QB+1];
    logic             big_reg  [QB+1];
    logic             sing_reg [QB+1];
    logic [OUT_W-1:0] quo_reg;
    logic             sout_reg;
    logic [OUT_W-1:0] quo_next;

    assign cm  = cof[ADJ_W-1] ? ADJ_W'(-cof) : ADJ_W'(cof);
    assign num = {cm, {OUT_SHIFT{1'b0}}};
    assign hi  = num[NUM_W-1:QB];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DET_W'(hi);
            lo_reg[0]   <= num[QB-1:0];
            q_reg[0]    <= '0;
            dm_reg[0]   <= det.mag;
            neg_reg[0]  <= (cof[ADJ_W-1] != det.neg) && (cm != '0);
            big_reg[0]  <= (DET_W+1)'(hi) >= (DET_W+1)'(det.mag);
            sing_reg[0] <= det.sing;
        end
    end

    for (genvar s = 0; s < QB; s++)
    begin : g_stage
        logic [DET_W:0] trial;
        logic           ge;

        assign trial = {rem_reg[s], lo_reg[s][QB-1]};
        assign ge    = trial >= {1'b0, dm_reg[s]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= ge ? DET_W'(trial - {1'b0, dm_reg[s]}) : DET_W'(trial);
                lo_reg[s+1]   <= {lo_reg[s][QB-2:0], 1'b0};
                q_reg[s+1]    <= {q_reg[s][QB-2:0], ge};
                dm_reg[s+1]   <= dm_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                big_reg[s+1]  <= big_reg[s];
                sing_reg[s+1] <= sing_reg[s];
            end
        end
    end

    always_comb
    begin
        if (sing_reg[QB])
            quo_next = '0;
        else if (neg_reg[QB])
        begin
            if (big_reg[QB] || q_reg[QB] > NEG_LIM)
                quo_next = NEG_LIM[OUT_W-1:0];
            else
                quo_next = OUT_W'(-q_reg[QB]);
        end
        else if (big_reg[QB] || q_reg[QB] > POS_LIM)
            quo_next = POS_LIM[OUT_W-1:0];
        else
            quo_next = q_reg[QB][OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg  <= quo_next;
            sout_reg <= sing_reg[QB];
        end
    end

    assign quo  = quo_reg;
    assign sing = sout_reg;
endmodule
`default_nettype wire

// ===== verif/matrix3x3_inverse_top_test.sv =====
// Testbench for the 3x3 matrix inverse: directed and random matrices, checked against a predictor.
`timescale 1ns / 100ps
module matrix3x3_inverse_top_test;
    import m3i_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUTD_W-1:0]   m_tdata;
    logic                m_tuser;

    typedef struct {
        logic [OUTD_W-1:0] inv;
        logic              sing;
    } inverse_t;

    inverse_t    inverse_q[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          stall_mode = 0;

    matrix3x3_inverse_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] quotient_sat(logic signed [ADJ_W-1:0] cof,
                                                 logic signed [DET_W-1:0] det);
        logic signed [127:0] num;
        logic signed [127:0] q;
        num = 128'(cof) <<< OUT_SHIFT;
        q = num / 128'(det);
        if (q > 128'sd2147483647)
            return 32'h7FFF_FFFF;
        if (q < -128'sd2147483648)
            return 32'h8000_0000;
        return q[31:0];
    endfunction

    function automatic inverse_t predict_inverse(logic [IN_W-1:0] data);
        logic signed [ENTRY_WIDTH-1:0] e[9];
        logic signed [ADJ_W-1:0]       a[9];
        logic signed [DET_W-1:0]       det;
        inverse_t                      r;
        for (int k = 0; k < 9; k++)
            e[k] = data[k*ENTRY_WIDTH +: ENTRY_WIDTH];
        a[0] = ADJ_W'(e[4]) * e[8] - ADJ_W'(e[7]) * e[5];
        a[1] = ADJ_W'(e[2]) * e[7] - ADJ_W'(e[8]) * e[1];
        a[2] = ADJ_W'(e[1]) * e[5] - ADJ_W'(e[4]) * e[2];
        a[3] = ADJ_W'(e[5]) * e[6] - ADJ_W'(e[8]) * e[3];
        a[4] = ADJ_W'(e[0]) * e[8] - ADJ_W'(e[6]) * e[2];
        a[5] = ADJ_W'(e[2]) * e[3] - ADJ_W'(e[5]) * e[0];
        a[6] = ADJ_W'(e[3]) * e[7] - ADJ_W'(e[6]) * e[4];
        a[7] = ADJ_W'(e[1]) * e[6] - ADJ_W'(e[7]) * e[0];
        a[8] = ADJ_W'(e[0]) * e[4] - ADJ_W'(e[3]) * e[1];
        det = DET_W'(e[0]) * a[0] + DET_W'(e[1]) * a[3] + DET_W'(e[2]) * a[6];
        r.inv = '0;
        r.sing = (det == 0);
        if (!r.sing)
            for (int k = 0; k < 9; k++)
                r.inv[k*OUT_W +: OUT_W] = quotient_sat(a[k], det);
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_matrix(logic [15:0] v[9]);
        logic [IN_W-1:0] d;
        d = '0;
        for (int k = 0; k < 9; k++)
            d[k*ENTRY_WIDTH +: ENTRY_WIDTH] = v[k];
        return d;
    endfunction

    task automatic send_matrix(logic [IN_W-1:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
        inverse_q.push_back(predict_inverse(data));
    endtask

    task automatic end_of_stream();
        s_tvalid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count % 500 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= cycle_count[3];
        endcase
        if (rst_n && m_tvalid && m_tready)
        begin
            if (inverse_q.size() == 0)
            begin
                $display("%0t: unexpected transfer %h %b", $time, m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                inverse_t x;
                x = inverse_q.pop_front();
                for (int k = 0; k < 9; k++)
                    if (m_tdata[k*OUT_W +: OUT_W] !== x.inv[k*OUT_W +: OUT_W])
                    begin
                        $display("%0t: inv%0d%0d expected %h actual %h", $time, k / 3, k % 3,
                                 x.inv[k*OUT_W +: OUT_W], m_tdata[k*OUT_W +: OUT_W]);
                        error_count++;
                    end
                if (m_tuser !== x.sing)
                begin
                    $display("%0t: singular expected %b actual %b", $time, x.sing, m_tuser);
                    error_count++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("matrix3x3_inverse_top_test: done, errors");
            $finish;
        end
    end

    task automatic test_directed();
        logic [15:0] v[9];
        v = '{16'h1000, 0, 0, 0, 16'h1000, 0, 0, 0, 16'h1000};
        send_matrix(pack_matrix(v));
        v = '{16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000};
        send_matrix(pack_matrix(v));
        v = '{16'h7FFF, 0, 0, 0, 16'h7FFF, 0, 0, 0, 16'h7FFF};
        send_matrix(pack_matrix(v));
        v = '{16'h0001, 0, 0, 0, 16'h0001, 0, 0, 0, 16'h0001};
        send_matrix(pack_matrix(v));
        v = '{16'hFFFF, 0, 0, 0, 16'h0001, 0, 0, 0, 16'h0001};
        send_matrix(pack_matrix(v));
        v = '{default: 16'h0000};
        send_matrix(pack_matrix(v));
        v = '{default: 16'hFFFF};
        send_matrix(pack_matrix(v));
        v = '{default: 16'h8000};
        send_matrix(pack_matrix(v));
        v = '{default: 16'h7FFF};
        send_matrix(pack_matrix(v));
        v = '{16'h1000, 16'h2000, 16'h3000, 16'h2000, 16'h4000, 16'h6000, 1, 2, 3};
        send_matrix(pack_matrix(v));
        v = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
              16'h8000, 16'h7FFF, 16'h7FFF};
        send_matrix(pack_matrix(v));
        v = '{0, 16'h1000, 0, 0, 0, 16'h1000, 16'h1000, 0, 0};
        send_matrix(pack_matrix(v));
        v = '{16'h8000, 16'h8000, 0, 16'h7FFF, 16'h8000, 0, 0, 0, 16'h0001};
        send_matrix(pack_matrix(v));
    endtask

    task automatic test_random(int count);
        logic [15:0] v[9];
        for (int n = 0; n < count; n++)
        begin
            for (int k = 0; k < 9; k++)
                case ($urandom_range(0, 5))
                    0: v[k] = 16'($urandom_range(0, 15) - 8);
                    1: v[k] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    2: v[k] = (k % 4 == 0) ? 16'h1000 : 16'h0000;
                    default: v[k] = 16'($urandom);
                endcase
            if ($urandom_range(0, 9) == 0)
                for (int c = 0; c < 3; c++)
                    v[3 + c] = v[c];
            send_matrix(pack_matrix(v));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1650);
        end_of_stream();
        while (inverse_q.size() != 0)
            @(posedge clk);
        repeat (LAT + 20) @(posedge clk);
        if (error_count == 0)
            $display("matrix3x3_inverse_top_test: done, clean");
        else
            $display("matrix3x3_inverse_top_test: done, errors");
        $finish;
    end
endmodule

// ===== matrix3x3_inverse_top.f =====
rtl/core/m3i_pkg.sv
rtl/core/m3i_adj.sv
rtl/core/m3i_div_lane.sv
rtl/core/matrix3x3_inverse_top.sv
verif/matrix3x3_inverse_top_test.sv
